[hdl/gtjd_pkg.sv]
package gtjd_pkg;

    // one queued job
    typedef struct packed {
        logic        exp;
        logic [31:0] gen;
        logic [15:0] tag;
    } t_entry;

    // what a cell does at the next edge
    typedef enum logic [1:0] {
        CO_HOLD,
        CO_LOAD,
        CO_SHR,   // take the entry of the cell nearer the front
        CO_SHL    // take the entry of the cell nearer the back
    } t_cell_op;

    typedef enum logic [2:0] {
        A_ENQUEUE  = 3'd0,
        A_SET_GEN  = 3'd1,
        A_TAKE     = 3'd2,
        A_DONE     = 3'd3,
        A_FLUSH    = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STALE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_DISABLED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PURGE,
        S_REPLY
    } t_state;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 120;
    localparam int PEND_W     = 5;

endpackage

[hdl/gtjd_cell.sv]
module gtjd_cell
    import gtjd_pkg::*;
(
    input  logic     i_clk,
    input  t_cell_op i_op,
    input  t_entry   i_from_front,
    input  t_entry   i_from_back,
    input  t_entry   i_load,
    output t_entry   o_q
);

    t_entry r_q;
    t_entry n_q;

    always_comb begin
        case (i_op)
            CO_LOAD: n_q = i_load;
            CO_SHR:  n_q = i_from_front;
            CO_SHL:  n_q = i_from_back;
            default: n_q = r_q;
        endcase
    end

    // payload only, occupancy is tracked by the fill count
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

[hdl/generation_tagged_job_deque.sv]
// Generation-tagged job deque. Jobs sit in a row of DEPTH cells, the front of
// the queue in cell 0; each cell shifts its job to a neighbour when a job is
// pushed at the front or popped, and a job pushed at the back is loaded
// straight into the first free cell. Every input transaction (tuser = action)
// gives exactly one output transaction (tuser = status). Enqueue, take next,
// report done, flush and undefined actions register their result as they are
// accepted, as does set generation on an empty queue. With pending entries
// set generation is accepted, then the purge state walks the chain one entry
// per cycle, testing the front cell and either dropping it or rotating it to
// the back of the occupied run so the kept jobs keep their order, then the
// reply state loads the result once the output register is free. A new
// transaction is taken only when no purge or purge result is pending and the
// output register is free or being emptied in the same cycle. The enable
// register only gates enqueue and is written through i_cfg_we.
module generation_tagged_job_deque
    import gtjd_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // job_tag[15:0], generation[47:16], export_mode[48], preview[49], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [2:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_tag[15:0], out_generation[47:16], out_export[48],
    // pending_count[53:49], dropped_count[85:54], completed_count[117:86], pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]            m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    // how the chain moves this cycle
    typedef enum logic [2:0] {
        M_NONE,
        M_TO_BACK,
        M_TO_FRONT,
        M_POP,
        M_PURGE_STEP
    } t_mode;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [CW-1:0] n);
        logic [32:0] s;
        s = {1'b0, a} + 33'(n);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic is_stale(input t_entry e, input logic [31:0] active);
        return !e.exp && (e.gen < active);
    endfunction

    // control state
    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_iter, n_iter;
    logic [31:0] r_active, n_active;
    logic [31:0] r_dropped, n_dropped;
    logic [31:0] r_completed, n_completed;
    logic        r_enabled, n_enabled;
    logic        r_out_valid, n_out_valid;

    // output payload
    t_status     r_out_status, n_out_status;
    t_entry      r_out_job, n_out_job;
    logic [PEND_W-1:0] r_out_pending, n_out_pending;
    logic [31:0] r_out_dropped, n_out_dropped;
    logic [31:0] r_out_completed, n_out_completed;

    // cell chain
    t_cell_op    c_op [DEPTH];
    t_entry      c_q  [DEPTH];
    t_entry      load_entry;
    t_mode       mode;

    logic        accept;
    logic        out_free;
    t_entry      in_entry;
    logic        in_preview;
    t_action     in_action;
    logic        head_stale;

    assign in_entry.tag = s_axis_tdata[15:0];
    assign in_entry.gen = s_axis_tdata[47:16];
    assign in_entry.exp = s_axis_tdata[48];
    assign in_preview   = s_axis_tdata[49];
    assign in_action    = t_action'(s_axis_tuser);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign head_stale    = is_stale(c_q[0], r_active);

    // next state, chain control and result
    always_comb begin
        logic        reply;
        n_state         = r_state;
        n_count         = r_count;
        n_iter          = r_iter;
        n_active        = r_active;
        n_dropped       = r_dropped;
        n_completed     = r_completed;
        n_enabled       = i_cfg_we ? i_cfg_wdata : r_enabled;
        n_out_valid     = r_out_valid && !m_axis_tready;
        n_out_status    = r_out_status;
        n_out_job       = r_out_job;
        mode            = M_NONE;
        reply           = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    reply        = 1'b1;
                    n_out_status = ST_OK;
                    n_out_job    = '0;
                    case (in_action)
                        A_ENQUEUE: begin
                            if (!r_enabled) begin
                                n_out_status = ST_DISABLED;
                            end else if (is_stale(in_entry, r_active)) begin
                                n_dropped    = sat_add(r_dropped, CW'(1));
                                n_out_status = ST_STALE;
                            end else if (r_count >= CW'(DEPTH)) begin
                                n_dropped    = sat_add(r_dropped, CW'(1));
                                n_out_status = ST_FULL;
                            end else begin
                                mode    = in_preview ? M_TO_FRONT : M_TO_BACK;
                                n_count = r_count + CW'(1);
                            end
                        end
                        A_SET_GEN: begin
                            n_active = in_entry.gen;
                            if (r_count != '0) begin
                                // result comes at the end of the purge
                                reply   = 1'b0;
                                n_iter  = r_count;
                                n_state = S_PURGE;
                            end
                        end
                        A_TAKE: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                mode      = M_POP;
                                n_count   = r_count - CW'(1);
                                n_out_job = c_q[0];
                                if (head_stale) begin
                                    n_dropped    = sat_add(r_dropped, CW'(1));
                                    n_out_status = ST_STALE;
                                end
                            end
                        end
                        A_DONE: begin
                            if (is_stale(in_entry, r_active)) begin
                                n_dropped    = sat_add(r_dropped, CW'(1));
                                n_out_status = ST_STALE;
                            end else if (r_completed != 32'hFFFF_FFFF) begin
                                n_completed = r_completed + 32'd1;
                            end
                        end
                        A_FLUSH: begin
                            n_dropped = sat_add(r_dropped, r_count);
                            n_count   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PURGE: begin
                // one front entry per cycle: drop it or rotate it to the back
                mode   = M_PURGE_STEP;
                n_iter = r_iter - CW'(1);
                if (head_stale) begin
                    n_dropped = sat_add(r_dropped, CW'(1));
                    n_count   = r_count - CW'(1);
                end
                if (r_iter == CW'(1)) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    reply        = 1'b1;
                    n_out_status = ST_OK;
                    n_out_job    = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (reply) begin
            n_out_valid = 1'b1;
        end
        n_out_pending   = reply ? PEND_W'(n_count) : r_out_pending;
        n_out_dropped   = reply ? n_dropped : r_out_dropped;
        n_out_completed = reply ? n_completed : r_out_completed;
    end

    // per-cell operation
    always_comb begin
        load_entry = (mode == M_PURGE_STEP) ? c_q[0] : in_entry;
        for (int i = 0; i < DEPTH; i++) begin
            case (mode)
                M_TO_BACK:    c_op[i] = (CW'(i) == r_count) ? CO_LOAD : CO_HOLD;
                M_TO_FRONT:   c_op[i] = (i == 0) ? CO_LOAD : CO_SHR;
                M_POP:        c_op[i] = CO_SHL;
                M_PURGE_STEP: c_op[i] = (CW'(i) == r_count - CW'(1) && !head_stale)
                                        ? CO_LOAD : CO_SHL;
                default:      c_op[i] = CO_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        gtjd_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (c_op[g]),
            .i_from_front ((g == 0) ? c_q[0] : c_q[(g == 0) ? 0 : g - 1]),
            .i_from_back  ((g == DEPTH - 1) ? c_q[g] : c_q[(g == DEPTH - 1) ? g : g + 1]),
            .i_load       (load_entry),
            .o_q          (c_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_iter      <= '0;
            r_active    <= '0;
            r_dropped   <= '0;
            r_completed <= '0;
            r_enabled   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_iter      <= n_iter;
            r_active    <= n_active;
            r_dropped   <= n_dropped;
            r_completed <= n_completed;
            r_enabled   <= n_enabled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status    <= n_out_status;
        r_out_job       <= n_out_job;
        r_out_pending   <= n_out_pending;
        r_out_dropped   <= n_out_dropped;
        r_out_completed <= n_out_completed;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_completed, r_out_dropped, r_out_pending,
                            r_out_job.exp, r_out_job.gen, r_out_job.tag};

endmodule
